// File: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache: operation codes,
// the entry record that moves along the cell row, and per-cell controls.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int unsigned KEY_W          = 32;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned CAP_W          = 5;
	localparam int unsigned ENTRIES_DEFAULT = 16;

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// One stored entry, as handed from a cell to its neighbor.
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	// Per-cell controls from the row controller.
	typedef struct packed {
		logic clear; // drop every entry (capacity write)
		logic load;  // take the neighbor's entry this cycle
		logic drop;  // the loaded entry lands past capacity: invalidate it
	} cell_ctrl_t;

endpackage

// File: rtl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One slot of the recency row: holds an entry, compares its key against the
// lookup key, and loads its neighbor's entry when told to shift.
// ----------------------------------------------------------------------------
module lkvc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvc_pkg::cell_ctrl_t          ctrl,
	input  lkvc_pkg::entry_t              prev,
	input  logic [lkvc_pkg::KEY_W-1:0]    lookup_key,
	output lkvc_pkg::entry_t              cur,
	output logic                          match
);
	import lkvc_pkg::*;

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= prev.valid & ~ctrl.drop;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign cur.valid = valid_q;
	assign cur.key   = key_q;
	assign cur.value = value_q;
	assign match     = valid_q && (key_q == lookup_key);

endmodule

// File: rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement,
// built as a row of cells ordered by recency.
// ----------------------------------------------------------------------------
// Cell 0 holds the most recent entry and each further cell the next older
// one; valid entries always form an unbroken run from cell 0. A transaction
// compares its key against every cell at once. A hit at cell p shifts cells
// 0..p down by one and puts the hit entry (with the new value on a put) into
// cell 0. A put of a new key shifts the whole row down and enters at cell 0;
// a cell at or beyond the capacity register drops what it receives, which
// evicts the least recent entry. A get returns one result transaction on the
// master side (tuser = found, tdata = stored value or all ones on a miss); a
// put returns nothing. The block takes one transaction per clock: the
// parallel key compare and the row shift complete in the same cycle, and a
// get's result sits in the output register from the next cycle. Input stalls
// only while that output register holds a result that is not taken.
// Capacity above ENTRIES behaves as ENTRIES; capacity zero stores nothing.
// Reset and every capacity write clear all valid bits together, so there
// is no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
	parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: capacity register
	input  logic                        capacity_we,
	input  logic [lkvc_pkg::CAP_W-1:0]  capacity_wdata,
	// request stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,  // [31:0] key, [63:32] value
	input  logic [0:0]                  s_tuser,  // [0] kind (0 get, 1 put)
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // [31:0] read_value
	output logic [0:0]                  m_tuser   // [0] found
);
	import lkvc_pkg::*;

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;

	logic [CAP_W-1:0]   capacity_q;
	logic               m_tvalid_q;
	logic [VALUE_W-1:0] m_tdata_q;
	logic               m_found_q;

	logic               accept;
	op_t                op;
	logic [KEY_W-1:0]   in_key;
	logic [VALUE_W-1:0] in_value;

	entry_t             link [ENTRIES+1];
	cell_ctrl_t         ctrl [ENTRIES];
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] at_or_above;
	logic               hit_any;
	logic [VALUE_W-1:0] hit_value;
	logic               do_insert;

	assign op       = op_t'(s_tuser[0]);
	assign in_key   = s_tdata[31:0];
	assign in_value = s_tdata[63:32];

	// Output register frees the input side: take a new transaction whenever
	// the held result is gone or leaves this cycle.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign hit_any = |hit_vec;

	// Select the hit entry's value; at most one cell matches.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value = hit_value | (link[i+1].value & {VALUE_W{hit_vec[i]}});
		end
	end

	// A new key enters only on a put miss with room allowed.
	assign do_insert = (op == OP_PUT) && !hit_any && (capacity_q != '0);

	// Front of the row: the entry that lands in cell 0.
	assign link[0].valid = 1'b1;
	assign link[0].key   = in_key;
	assign link[0].value = (op == OP_PUT) ? in_value : hit_value;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		// Cells at or before the hit position move down on a touch.
		assign at_or_above[i] = |(hit_vec >> i);

		assign ctrl[i].clear = capacity_we;
		assign ctrl[i].load  = accept && ((hit_any && at_or_above[i]) || do_insert);
		// On insert, anything pushed to or beyond capacity is evicted.
		assign ctrl[i].drop  = !hit_any && (CMP_W'(i) >= CMP_W'(capacity_q));

		lkvc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.prev       (link[i]),
			.lookup_key (in_key),
			.cur        (link[i+1]),
			.match      (hit_vec[i])
		);

		assign valid_vec[i] = link[i+1].valid;
	end

	// Capacity register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
			if (accept && (op == OP_GET)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until a new get replaces it.
	always_ff @(posedge clk) begin
		if (accept && (op == OP_GET)) begin
			m_found_q <= hit_any;
			m_tdata_q <= hit_any ? hit_value : MISS_VALUE;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_found_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	logic [ENTRIES:0] valid_run;
	assign valid_run = {1'b0, valid_vec} + (ENTRIES+1)'(1);

	// Keys are unique among valid cells.
	a_hit_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell matched the lookup key");

	// Valid entries stay packed from cell 0.
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(valid_run))
		else $error("valid cells do not form a run from cell 0");

	// Occupancy never exceeds the capacity register.
	a_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) <= int'(capacity_q))
		else $error("more valid cells than capacity");

	// A capacity write empties the row.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		capacity_we |=> (valid_vec == '0))
		else $error("row not cleared after capacity write");

	// Every accepted get shows a result next cycle.
	a_get_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_GET)) |=> m_tvalid_q)
		else $error("accepted get produced no result");

endmodule

// File: tb/sv/lru_cache_checker.sv
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches the capacity port and both streams of the LRU key-value cache,
// keeps its own recency-ordered copy of the table, and compares every
// lookup result with the one predicted when the get was accepted.
// ----------------------------------------------------------------------------
module lru_cache_checker
	import lkvc_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_we,
	input  logic [CAP_W-1:0] capacity_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [63:0]      s_tdata,  // [31:0] key, [63:32] value
	input  logic [0:0]       s_tuser,  // [0] kind
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [31:0]      m_tdata,  // [31:0] read_value
	input  logic [0:0]       m_tuser,  // [0] found
	output int               pending,
	output int               errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] data;
	} read_result_t;

	logic [KEY_W-1:0]   tag_q  [ENTRIES];
	logic [VALUE_W-1:0] data_q [ENTRIES];
	bit                 live   [ENTRIES];
	int unsigned        age    [ENTRIES]; // 0 = most recent
	int unsigned        fill;
	int unsigned        cap_setting;
	read_result_t       pending_reads[$];
	int                 mismatch_count;

	function automatic void wipe_table();
		for (int i = 0; i < ENTRIES; i++) begin
			live[i] = 1'b0;
			age[i]  = 0;
		end
		fill = 0;
	endfunction

	function automatic int find_key(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (live[i] && tag_q[i] == k)
				return i;
		return -1;
	endfunction

	// Entries newer than the touched one age by one.
	function automatic void make_newest(int slot);
		int unsigned r;
		r = age[slot];
		for (int i = 0; i < ENTRIES; i++)
			if (live[i] && age[i] < r)
				age[i]++;
		age[slot] = 0;
	endfunction

	function automatic void evict_oldest();
		for (int i = 0; i < ENTRIES; i++) begin
			if (live[i] && age[i] + 1 == fill) begin
				live[i] = 1'b0;
				age[i]  = 0;
				fill--;
				return;
			end
		end
	endfunction

	function automatic void insert_key(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
		int slot;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!live[i]) begin
				slot = i;
				break;
			end
		end
		if (slot < 0)
			return;
		for (int i = 0; i < ENTRIES; i++)
			if (live[i])
				age[i]++;
		tag_q[slot]  = k;
		data_q[slot] = v;
		live[slot]   = 1'b1;
		age[slot]    = 0;
		fill++;
	endfunction

	function automatic void predict_request(op_t op, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v);
		int          slot;
		int unsigned limit;
		limit = (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
		slot  = find_key(k);
		if (op == OP_GET) begin
			if (slot >= 0) begin
				make_newest(slot);
				pending_reads.push_back('{found: 1'b1, data: data_q[slot]});
			end else begin
				pending_reads.push_back('{found: 1'b0, data: MISS_VALUE});
			end
		end else if (slot >= 0) begin
			data_q[slot] = v;
			make_newest(slot);
		end else if (limit != 0) begin
			while (fill >= limit && fill != 0)
				evict_oldest();
			insert_key(k, v);
		end
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (mismatch_count < 10)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		mismatch_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		read_result_t want;
		if (!arst_n) begin
			wipe_table();
			cap_setting = CAP_RESET;
			pending_reads.delete();
			mismatch_count = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			if (capacity_we) begin
				cap_setting = capacity_wdata;
				wipe_table();
			end
			if (m_tvalid && m_tready) begin
				if (pending_reads.size() == 0) begin
					flag_mismatch("unexpected result", '0, m_tdata);
				end else begin
					want = pending_reads.pop_front();
					if (m_tuser[0] !== want.found)
						flag_mismatch("found", 32'(want.found), 32'(m_tuser[0]));
					if (m_tdata !== want.data)
						flag_mismatch("read_value", want.data, m_tdata);
				end
			end
			if (s_tvalid && s_tready)
				predict_request(op_t'(s_tuser[0]), s_tdata[31:0], s_tdata[63:32]);
			pending <= pending_reads.size();
			errors  <= mismatch_count;
		end
	end

endmodule

// File: tb/sv/lru_key_value_cache_core_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_tb
// Stimulus and verdict for the LRU key-value cache: a directed opening on
// boundary keys, updates and eviction, then randomized get/put traffic over
// small key pools at several capacity settings, with random stalls on both
// streams. Checking lives in lru_cache_checker.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core_tb;
	import lkvc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRIES = 16;
	localparam int          PHASES  = 8;

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             capacity_we    = 1'b0;
	logic [CAP_W-1:0] capacity_wdata = '0;
	logic             s_tvalid       = 1'b0;
	logic             s_tready;
	logic [63:0]      s_tdata        = '0;  // [31:0] key, [63:32] value
	logic [0:0]       s_tuser        = '0;  // [0] kind
	logic             m_tvalid;
	logic             m_tready       = 1'b0;
	logic [31:0]      m_tdata;              // [31:0] read_value
	logic [0:0]       m_tuser;              // [0] found

	int pending;
	int errors;
	bit calm = 1'b0; // suppress idling on both sides while set

	always #5 clk = ~clk;

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

	lru_cache_checker #(
		.ENTRIES(ENTRIES)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.pending       (pending),
		.errors        (errors)
	);

	// Result side: stall at random about 6 percent of the time, never during a calm stretch.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 6);
	end

	// Present one request and hold it until the transaction completes. Leave
	// tvalid high afterwards so back-to-back requests stream without a bubble.
	task automatic send_item(input op_t op, input logic [31:0] k, input logic [31:0] v);
		while (!calm && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, k};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Drop tvalid and wait until every predicted result has been taken, then
	// let a trailing put settle in the row.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register; only call with the block idle.
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		settle();
		capacity_we    <= 1'b1;
		capacity_wdata <= c;
		@(posedge clk);
		capacity_we    <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] caps [PHASES];
		logic [31:0]      key_pool [20];
		int unsigned      pool_size;
		int unsigned      lim;
		logic [31:0]      k;

		// Extremes first (full, saturated, one, zero), then 17, 2 and 9; the last phase draws a random one.
		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd2, 5'd9, 5'd0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset capacity: miss on an empty table, boundary keys and
		// values, a stored value equal to the miss pattern, and an update.
		send_item(OP_GET, 32'h0000_0000, $urandom());
		send_item(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_GET, 32'h8000_0000, $urandom());
		send_item(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_GET, 32'h7fff_ffff, $urandom());
		send_item(OP_PUT, 32'h0000_0000, 32'hffff_ffff);
		send_item(OP_GET, 32'h0000_0000, $urandom());
		send_item(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
		send_item(OP_GET, 32'hffff_ffff, $urandom());
		send_item(OP_PUT, 32'h0000_0000, 32'h0000_1234);
		send_item(OP_GET, 32'h0000_0000, $urandom());
		send_item(OP_GET, 32'h0000_0001, $urandom());

		// Capacity two: a get refreshes A, so the next new key evicts B.
		write_capacity(5'd2);
		send_item(OP_PUT, 32'h0000_00a0, 32'h1111_1111);
		send_item(OP_PUT, 32'h0000_00b0, 32'h2222_2222);
		send_item(OP_GET, 32'h0000_00a0, $urandom());
		send_item(OP_PUT, 32'h0000_00c0, 32'h3333_3333);
		send_item(OP_GET, 32'h0000_00b0, $urandom());
		send_item(OP_GET, 32'h0000_00a0, $urandom());
		send_item(OP_GET, 32'h0000_00c0, $urandom());

		// Capacity zero: a put of a new key stores nothing.
		write_capacity(5'd0);
		send_item(OP_PUT, 32'h0000_0055, 32'h5555_5555);
		send_item(OP_GET, 32'h0000_0055, $urandom());

		// Random phases: keys come mostly from a pool a little larger than the
		// capacity, so hits, updates and evictions all happen often.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1)
				write_capacity(CAP_W'($urandom_range(1, 16)));
			else
				write_capacity(caps[ph]);
			lim       = (capacity_wdata > ENTRIES) ? ENTRIES : capacity_wdata;
			pool_size = (lim + 4 > 20) ? 20 : lim + 4;
			for (int i = 0; i < 20; i++)
				key_pool[i] = $urandom();
			calm = (ph == 2); // one long stretch with no idling at all
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 9) == 0)
					k = $urandom();
				else
					k = key_pool[$urandom_range(0, pool_size - 1)];
				send_item(op_t'($urandom_range(0, 1)), k, $urandom());
			end
			calm = 1'b0;
		end

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
